// ===== rtl/wake_word_stream_cipher_assert.svh =====
// Assertion macros used by the checker of the cipher block.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
// No other dependencies.
`ifndef WAKE_WORD_STREAM_CIPHER_ASSERT_SVH
`define WAKE_WORD_STREAM_CIPHER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define WWSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds from the cycle after ante.
`define WWSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wwsc_pkg.sv =====
// Shared types and constants of the WAKE word cipher block.
// No dependencies; every module of the block but wwsc_ram imports it.
package wwsc_pkg;

    localparam int WORD_W    = 32;
    localparam int TBL_DEPTH = 257;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int CFG_AW    = 3;
    localparam int OUT_W     = 5 * WORD_W;

    // Expansion passes
    localparam int FILL_LAST = 255;
    localparam int XMIX_LAST = 256;
    localparam int SHUF_LAST = 255;
    localparam int TOP_IDX   = 256;
    localparam int MIX_LEN   = 23;
    localparam int MIX_OFS   = 89;
    localparam int X_SEED    = 33;
    localparam int Z_SEED    = 59;

    localparam logic [WORD_W-1:0] Z_SET_MASK = 32'h0100_0001;
    localparam logic [WORD_W-1:0] X_CLR_MASK = 32'hff7f_ffff;
    localparam logic [WORD_W-1:0] LOW24_MASK = 32'h00ff_ffff;

    localparam logic [WORD_W-1:0] FILL_CONSTS [8] = '{
        32'h726a_8f3b, 32'he69a_3b5c, 32'hd3c7_1fe5, 32'hab3c_73d2,
        32'h4d3a_8eb3, 32'h0396_d6e8, 32'h3d4c_2f7a, 32'h9ee2_7cf3
    };

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_KEY0    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_KEY1    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_KEY2    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_KEY3    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DECRYPT = 3'd4;

    // Beat kinds carried in s_tuser[0]
    localparam logic OP_EXPAND = 1'b0;
    localparam logic OP_DATA   = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_STEP_B,
        CMD_STEP_C,
        CMD_STEP_D,
        CMD_FINISH,
        CMD_FILL,
        CMD_XMIX,
        CMD_XTOP,
        CMD_SH_IDX,
        CMD_SH_Y,
        CMD_SH_WP,
        CMD_SH_WY
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t         code;
        logic [TBL_AW-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/wwsc_ram.sv =====
// Generic RAM: one write port, two read ports with enabled, registered read.
// No dependencies.
module wwsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/wwsc_ctrl.sv =====
// Sequencer of the cipher block: word steps and the key expansion passes.
// Depends on wwsc_pkg; drives wwsc_dp through a command struct.
module wwsc_ctrl
    import wwsc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     in_op,
    input  dp_stat_t stat,
    output logic     s_tready,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_XMIX,
        S_XTOP,
        S_SH_IDX,
        S_SH_Y,
        S_SH_WP,
        S_SH_WY,
        S_W_B,
        S_W_C,
        S_W_D,
        S_W_FIN
    } state_t;

    state_t            state_reg;
    logic              ready_reg;
    logic [TBL_AW-1:0] p_reg;
    logic              accept;

    assign accept   = s_tvalid && ready_reg;
    assign s_tready = ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
            p_reg     <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        ready_reg <= 1'b0;
                        p_reg     <= '0;
                        state_reg <= (in_op == OP_DATA) ? S_W_B : S_FILL;
                    end
                end
                S_FILL: begin
                    if (p_reg == TBL_AW'(FILL_LAST)) begin
                        p_reg     <= '0;
                        state_reg <= S_XMIX;
                    end else begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                S_XMIX: begin
                    if (p_reg == TBL_AW'(XMIX_LAST)) begin
                        state_reg <= S_XTOP;
                    end else begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                S_XTOP: begin
                    p_reg     <= '0;
                    state_reg <= S_SH_IDX;
                end
                S_SH_IDX: state_reg <= S_SH_Y;
                S_SH_Y:   state_reg <= S_SH_WP;
                S_SH_WP:  state_reg <= S_SH_WY;
                S_SH_WY: begin
                    if (p_reg == TBL_AW'(SHUF_LAST)) begin
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= S_SH_IDX;
                    end
                end
                S_W_B: state_reg <= S_W_C;
                S_W_C: state_reg <= S_W_D;
                S_W_D: state_reg <= S_W_FIN;
                S_W_FIN: begin
                    if (stat.out_free) begin
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    ready_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        cmd.idx = p_reg;
        unique case (state_reg)
            S_IDLE:   cmd.code = (accept && in_op == OP_DATA) ? CMD_LOAD : CMD_NONE;
            S_FILL:   cmd.code = CMD_FILL;
            S_XMIX:   cmd.code = CMD_XMIX;
            S_XTOP:   cmd.code = CMD_XTOP;
            S_SH_IDX: cmd.code = CMD_SH_IDX;
            S_SH_Y:   cmd.code = CMD_SH_Y;
            S_SH_WP:  cmd.code = CMD_SH_WP;
            S_SH_WY:  cmd.code = CMD_SH_WY;
            S_W_B:    cmd.code = CMD_STEP_B;
            S_W_C:    cmd.code = CMD_STEP_C;
            S_W_D:    cmd.code = CMD_STEP_D;
            S_W_FIN:  cmd.code = stat.out_free ? CMD_FINISH : CMD_NONE;
            default:  cmd.code = CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/wwsc_dp.sv =====
// Datapath of the cipher block: key and running registers, table RAM,
// expansion registers and the output register. Depends on wwsc_pkg, wwsc_ram.
module wwsc_dp
    import wwsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [WORD_W-1:0] cfg_wdata,
    input  logic [WORD_W-1:0] in_data,
    input  logic              in_first,
    input  logic              in_last,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast
);

    logic [WORD_W-1:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic              decrypt_reg;
    logic [WORD_W-1:0] chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic [WORD_W-1:0] sum_reg, result_reg;
    logic              last_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;
    logic [WORD_W-1:0] win1_reg, win2_reg, win3_reg, win4_reg;
    logic [WORD_W-1:0] x_reg, z_reg, t0_reg;
    logic [7:0]        y_reg;

    logic              ram_we, re_a, re_b;
    logic [TBL_AW-1:0] waddr, raddr_a, raddr_b;
    logic [WORD_W-1:0] wdata, rdata_a, rdata_b;

    logic [WORD_W-1:0] chain_a_sel, chain_d_sel, word_res, feedback, sum_a;
    logic [WORD_W-1:0] mix_val, addend, sum_mix;
    logic [WORD_W-1:0] key_sel, fill_x, fill_val;
    logic [TBL_AW-1:0] q_idx;
    logic [WORD_W-1:0] mix_add, x_base, x_next, x_word;
    logic [7:0]        y_new;

    wwsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re_a    (re_a),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .re_b    (re_b),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    // Word step: keystream, feedback and the first lookup sum
    assign chain_a_sel = in_first ? key0_reg : chain_a_reg;
    assign chain_d_sel = in_first ? key3_reg : chain_d_reg;
    assign word_res    = in_data ^ chain_d_sel;
    assign feedback    = decrypt_reg ? in_data : word_res;
    assign sum_a       = chain_a_sel + feedback;
    assign mix_val     = {8'h00, sum_reg[WORD_W-1:8]} ^ rdata_a;
    assign sum_mix     = addend + mix_val;

    always_comb begin
        unique case (cmd.code)
            CMD_STEP_B: addend = chain_b_reg;
            CMD_STEP_C: addend = chain_c_reg;
            default:    addend = chain_d_reg;
        endcase
    end

    // Fill pass
    always_comb begin
        unique case (cmd.idx[1:0])
            2'd0:    key_sel = key0_reg;
            2'd1:    key_sel = key1_reg;
            2'd2:    key_sel = key2_reg;
            default: key_sel = key3_reg;
        endcase
    end

    assign fill_x   = win4_reg + win1_reg;
    assign fill_val = (cmd.idx < TBL_AW'(4)) ? key_sel
                    : ({3'b000, fill_x[WORD_W-1:3]} ^ FILL_CONSTS[fill_x[2:0]]);

    // Mix and top-byte pass: write entry q_idx while reading the next one
    assign q_idx   = cmd.idx - 1'b1;
    assign mix_add = (q_idx < TBL_AW'(MIX_LEN)) ? rdata_b : '0;
    assign x_base  = rdata_a + mix_add;
    assign x_next  = (x_reg & X_CLR_MASK) + z_reg;
    assign x_word  = (x_base & LOW24_MASK) ^ x_next;

    // Shuffle pass
    assign y_new = rdata_a[7:0] ^ y_reg;

    always_comb begin
        ram_we  = 1'b0;
        waddr   = '0;
        wdata   = '0;
        re_a    = 1'b0;
        raddr_a = '0;
        re_b    = 1'b0;
        raddr_b = '0;
        unique case (cmd.code)
            CMD_LOAD: begin
                re_a    = 1'b1;
                raddr_a = {1'b0, sum_a[7:0]};
            end
            CMD_STEP_B, CMD_STEP_C, CMD_STEP_D: begin
                re_a    = 1'b1;
                raddr_a = {1'b0, sum_mix[7:0]};
            end
            CMD_FILL: begin
                ram_we = 1'b1;
                waddr  = cmd.idx;
                wdata  = fill_val;
            end
            CMD_XMIX: begin
                if (cmd.idx != TBL_AW'(XMIX_LAST)) begin
                    re_a    = 1'b1;
                    raddr_a = cmd.idx;
                end
                if (cmd.idx < TBL_AW'(MIX_LEN)) begin
                    re_b    = 1'b1;
                    raddr_b = cmd.idx + TBL_AW'(MIX_OFS);
                end
                if (cmd.idx != '0) begin
                    ram_we = 1'b1;
                    waddr  = q_idx;
                    wdata  = x_word;
                end
            end
            CMD_XTOP: begin
                ram_we = 1'b1;
                waddr  = TBL_AW'(TOP_IDX);
                wdata  = t0_reg;
            end
            CMD_SH_IDX: begin
                re_a    = 1'b1;
                raddr_a = {1'b0, cmd.idx[7:0] ^ y_reg};
            end
            CMD_SH_Y: begin
                re_a    = 1'b1;
                raddr_a = {1'b0, y_new};
                re_b    = 1'b1;
                raddr_b = cmd.idx + 1'b1;
            end
            CMD_SH_WP: begin
                ram_we = 1'b1;
                waddr  = cmd.idx;
                wdata  = rdata_a;
            end
            CMD_SH_WY: begin
                ram_we = 1'b1;
                waddr  = {1'b0, y_reg};
                wdata  = rdata_b;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state and registers with a reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            decrypt_reg   <= 1'b0;
            chain_a_reg   <= '0;
            chain_b_reg   <= '0;
            chain_c_reg   <= '0;
            chain_d_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_KEY0:    key0_reg    <= cfg_wdata;
                    CFG_KEY1:    key1_reg    <= cfg_wdata;
                    CFG_KEY2:    key2_reg    <= cfg_wdata;
                    CFG_KEY3:    key3_reg    <= cfg_wdata;
                    CFG_DECRYPT: decrypt_reg <= cfg_wdata[0];
                    default:     decrypt_reg <= decrypt_reg;
                endcase
            end
            if (cmd.code == CMD_FINISH) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.code)
                CMD_LOAD: begin
                    if (in_first) begin
                        chain_b_reg <= key1_reg;
                        chain_c_reg <= key2_reg;
                        chain_d_reg <= key3_reg;
                    end
                end
                CMD_STEP_B: chain_a_reg <= mix_val;
                CMD_STEP_C: chain_b_reg <= mix_val;
                CMD_STEP_D: chain_c_reg <= mix_val;
                CMD_FINISH: chain_d_reg <= mix_val;
                default:    chain_d_reg <= chain_d_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.code)
            CMD_LOAD: begin
                sum_reg    <= sum_a;
                result_reg <= word_res;
                last_reg   <= in_last;
            end
            CMD_STEP_B, CMD_STEP_C, CMD_STEP_D: begin
                sum_reg <= sum_mix;
            end
            CMD_FINISH: begin
                out_data_reg <= {mix_val, chain_c_reg, chain_b_reg, chain_a_reg, result_reg};
                out_last_reg <= last_reg;
            end
            CMD_FILL: begin
                win4_reg <= win3_reg;
                win3_reg <= win2_reg;
                win2_reg <= win1_reg;
                win1_reg <= fill_val;
                if (cmd.idx == TBL_AW'(X_SEED)) begin
                    x_reg <= fill_val;
                end
                if (cmd.idx == TBL_AW'(Z_SEED)) begin
                    z_reg <= (fill_val | Z_SET_MASK) & X_CLR_MASK;
                end
            end
            CMD_XMIX: begin
                if (cmd.idx != '0) begin
                    x_reg <= x_next;
                end
                if (cmd.idx == TBL_AW'(1)) begin
                    t0_reg <= x_word;
                end
            end
            CMD_XTOP: y_reg <= x_reg[7:0];
            CMD_SH_Y: y_reg <= y_new;
            default:  y_reg <= y_reg;
        endcase
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign m_tlast       = out_last_reg;

endmodule

// ===== rtl/wake_word_stream_cipher.sv =====
// Top level of the WAKE word cipher with ciphertext feedback.
// Depends on wwsc_pkg, wwsc_ctrl, wwsc_dp (and wwsc_ram below it).
//
// Use:
// - Write key words 0..3 and the decrypt flag through cfg_wr_en/cfg_index/
//   cfg_wdata while the block is idle (index 0..3 keys, 4 decrypt flag).
// - Send an expand beat (s_tuser[0] = 0) to build the 257-entry table from
//   the key. It gives no result beat and keeps s_tready low through the fill
//   pass, the mix/top-byte pass, the top entry write and the shuffle pass.
// - Send data beats (s_tuser[0] = 1); s_tuser[1] reloads the running
//   registers from the key first, s_tlast is passed through to m_tlast.
// - Each data beat gives one result beat: m_tdata holds the output word and
//   the four running registers after the step. The input takes no new word
//   until the current one is done: four dependent table lookups, at the accept
//   and in steps B, C and D, then the last mix as input reopens.
// - A finished result waits in the output register; the next data beat is
//   accepted meanwhile, and its last step stalls until that register drains.
// - Reset clears keys, the decrypt flag, the running registers and the
//   output valid flag; the table holds nothing defined until an expand beat.
module wake_word_stream_cipher
    import wwsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Input beats
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,   // [31:0] data_in
    input  logic [1:0]        s_tuser,   // [0] op, [1] first
    input  logic              s_tlast,
    // Result beats
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [31:0] data_out, [63:32] run_reg_a,
                                         // [95:64] run_reg_b, [127:96] run_reg_c,
                                         // [159:128] run_reg_d
    output logic              m_tlast,
    // Configuration writes
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [WORD_W-1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence word steps and expansion passes
    wwsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tuser[0]),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Hold keys, running registers, table and the result beat
    wwsc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_first  (s_tuser[1]),
        .in_last   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/wwsc_checker.sv =====
// Port-level checks of the cipher block, bound to the top level.
// Depends on wwsc_pkg and the macro header.
`include "wake_word_stream_cipher_assert.svh"

module wwsc_checker
    import wwsc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [1:0]       s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    // A stalled result beat holds
    `WWSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // One beat at a time: ready drops after every accept
    `WWSC_ASSERT_NEXT(a_one_beat, s_tvalid && s_tready, !s_tready, "beat accepted while busy")

    // A data beat keeps the input closed through its steps B, C, D and finish
    `WWSC_ASSERT_NEXT(a_word_busy, s_tvalid && s_tready && s_tuser[0] == OP_DATA, !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready, "input reopened during a word")

    // A fresh result appears only after a data beat
    `WWSC_ASSERT_NOW(a_out_origin, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tuser[0] == OP_DATA, 5), "result beat without a data beat")

endmodule

bind wake_word_stream_cipher wwsc_checker u_wwsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
